>>> rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg - shared types and constants of the chunked body decoder
// phase and result-kind codes, the parser result bundle, and the header key
// ----------------------------------------------------------------------------
package hcbd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SIZE   = 2'd1,
    PH_DATA   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD     = 2'd0,
    KIND_SIZE        = 2'd1,
    KIND_END         = 2'd2,
    KIND_NOT_CHUNKED = 2'd3
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] chunk_length;
    logic [31:0] total_length;
    logic        last;
  } hcbd_result_t;

  localparam logic [7:0]  CHAR_CR     = 8'h0D;
  localparam logic [7:0]  CHAR_LF     = 8'h0A;
  localparam logic [7:0]  CHAR_COLON  = 8'h3A;
  localparam logic [7:0]  CHAR_SPACE  = 8'h20;
  localparam logic [4:0]  KEY_LEN     = 5'd17;
  localparam logic [55:0] WORD_CHUNKED = 56'h6368756E6B6564;

  // "Transfer-Encoding", one character per position
  function automatic logic [7:0] key_char(input logic [4:0] pos);
    logic [7:0] c;
    unique case (pos)
      5'd0:    c = "T";
      5'd1:    c = "r";
      5'd2:    c = "a";
      5'd3:    c = "n";
      5'd4:    c = "s";
      5'd5:    c = "f";
      5'd6:    c = "e";
      5'd7:    c = "r";
      5'd8:    c = "-";
      5'd9:    c = "E";
      5'd10:   c = "n";
      5'd11:   c = "c";
      5'd12:   c = "o";
      5'd13:   c = "d";
      5'd14:   c = "i";
      5'd15:   c = "n";
      5'd16:   c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/hcbd_parser.sv
// ----------------------------------------------------------------------------
// hcbd_parser - per-byte parse state of the chunked body decoder
// holds header, size-line and data state; gives the result of the byte
// offered and advances its state when step is high
// ----------------------------------------------------------------------------
module hcbd_parser
  import hcbd_pkg::*;
#(
  parameter int SZ_W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   byte_in,
  output hcbd_result_t res
);

  phase_t            phase_r, phase_nxt;
  logic              prev_cr_r, prev_cr_nxt;
  logic [4:0]        line_pos_r, line_pos_nxt;
  logic              key_match_r, key_match_nxt;
  logic              colon_r, colon_nxt;
  logic              key_enc_r, key_enc_nxt;
  logic [55:0]       window_r, window_nxt;
  logic              chunked_r, chunked_nxt;
  logic [SZ_W-1:0]   size_acc_r, size_acc_nxt;
  logic              closed_r, closed_nxt;
  logic [SZ_W:0]     remain_r, remain_nxt;
  logic [31:0]       total_r, total_nxt;

  logic              line_end;
  logic              is_hex;
  logic [3:0]        hex_val;
  logic [SZ_W+3:0]   acc_shift;
  logic [SZ_W:0]     remain_dec;
  logic [32:0]       total_sum;
  logic [7:0]        lower;
  logic [55:0]       window_shift;

  assign line_end = (byte_in == CHAR_LF) && prev_cr_r;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    priority if (byte_in >= "0" && byte_in <= "9") begin
      hex_val = 4'(byte_in - "0");
    end else if (byte_in >= "a" && byte_in <= "f") begin
      hex_val = 4'(byte_in - "a" + 8'd10);
    end else if (byte_in >= "A" && byte_in <= "F") begin
      hex_val = 4'(byte_in - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign acc_shift    = {size_acc_r, hex_val};
  assign remain_dec   = (remain_r != '0) ? remain_r - 1'b1 : remain_r;
  assign total_sum    = {1'b0, total_r} + {1'b0, 32'(size_acc_r)};
  assign lower        = (byte_in >= "A" && byte_in <= "Z") ? byte_in + 8'd32 : byte_in;
  assign window_shift = {window_r[47:0], lower};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (line_end && line_pos_r == 5'd1) begin
          phase_nxt = chunked_r ? PH_SIZE : PH_DONE;
        end
      end
      PH_SIZE: begin
        if (line_end) begin
          phase_nxt = (size_acc_r == '0) ? PH_DONE : PH_DATA;
        end
      end
      PH_DATA: begin
        if (remain_dec == '0) begin
          phase_nxt = PH_SIZE;
        end
      end
      PH_DONE: phase_nxt = PH_DONE;
    endcase
  end

  // result of the byte on offer
  always_comb begin
    res = '0;
    unique case (phase_r)
      PH_HEADER: begin
        if (line_end && line_pos_r == 5'd1 && !chunked_r) begin
          res.valid = 1'b1;
          res.kind  = KIND_NOT_CHUNKED;
        end
      end
      PH_SIZE: begin
        if (line_end) begin
          res.valid = 1'b1;
          if (size_acc_r == '0) begin
            res.kind         = KIND_END;
            res.total_length = total_r;
          end else begin
            res.kind         = KIND_SIZE;
            res.chunk_length = 32'(size_acc_r);
          end
        end
      end
      PH_DATA: begin
        res.valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = byte_in;
        res.last      = (remain_r <= (SZ_W+1)'(1));
      end
      PH_DONE: res = '0;
    endcase
  end

  // data path state
  always_comb begin
    prev_cr_nxt   = prev_cr_r;
    line_pos_nxt  = line_pos_r;
    key_match_nxt = key_match_r;
    colon_nxt     = colon_r;
    key_enc_nxt   = key_enc_r;
    window_nxt    = window_r;
    chunked_nxt   = chunked_r;
    size_acc_nxt  = size_acc_r;
    closed_nxt    = closed_r;
    remain_nxt    = remain_r;
    total_nxt     = total_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (line_end) begin
          prev_cr_nxt  = 1'b0;
          line_pos_nxt = '0;
          if (line_pos_r == 5'd1) begin
            size_acc_nxt = '0;
            closed_nxt   = 1'b0;
          end else begin
            key_match_nxt = 1'b1;
            colon_nxt     = 1'b0;
            key_enc_nxt   = 1'b0;
            window_nxt    = '0;
          end
        end else begin
          if (!colon_r) begin
            if (byte_in == CHAR_COLON) begin
              colon_nxt   = 1'b1;
              key_enc_nxt = key_match_r && (line_pos_r == KEY_LEN);
              window_nxt  = '0;
            end else if (line_pos_r >= KEY_LEN || byte_in != key_char(line_pos_r)) begin
              key_match_nxt = 1'b0;
            end
          end else if (key_enc_r) begin
            window_nxt = window_shift;
            if (window_shift == WORD_CHUNKED) chunked_nxt = 1'b1;
          end
          if (line_pos_r != 5'd31) line_pos_nxt = line_pos_r + 5'd1;
          prev_cr_nxt = (byte_in == CHAR_CR);
        end
      end
      PH_SIZE: begin
        if (line_end) begin
          if (size_acc_r != '0) begin
            total_nxt  = total_sum[32] ? '1 : total_sum[31:0];
            remain_nxt = {1'b0, size_acc_r} + (SZ_W+1)'(2);
          end
        end else begin
          prev_cr_nxt = (byte_in == CHAR_CR);
          if (!closed_r) begin
            if (is_hex) begin
              size_acc_nxt = (acc_shift[SZ_W+3:SZ_W] != 4'd0) ? '1 : acc_shift[SZ_W-1:0];
              line_pos_nxt = 5'd1;
            end else if (line_pos_r == '0 &&
                         (byte_in == CHAR_SPACE || (byte_in >= 8'h09 && byte_in <= 8'h0D))) begin
              // leading white space skipped
            end else begin
              closed_nxt = 1'b1;
            end
          end
        end
      end
      PH_DATA: begin
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          prev_cr_nxt  = 1'b0;
          line_pos_nxt = '0;
          size_acc_nxt = '0;
          closed_nxt   = 1'b0;
        end
      end
      PH_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      prev_cr_r   <= 1'b0;
      line_pos_r  <= '0;
      key_match_r <= 1'b1;
      colon_r     <= 1'b0;
      key_enc_r   <= 1'b0;
      window_r    <= '0;
      chunked_r   <= 1'b0;
      size_acc_r  <= '0;
      closed_r    <= 1'b0;
      remain_r    <= '0;
      total_r     <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      prev_cr_r   <= prev_cr_nxt;
      line_pos_r  <= line_pos_nxt;
      key_match_r <= key_match_nxt;
      colon_r     <= colon_nxt;
      key_enc_r   <= key_enc_nxt;
      window_r    <= window_nxt;
      chunked_r   <= chunked_nxt;
      size_acc_r  <= size_acc_nxt;
      closed_r    <= closed_nxt;
      remain_r    <= remain_nxt;
      total_r     <= total_nxt;
    end
  end

endmodule

>>> rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder - chunked transfer body decoder, one byte a clock unless stalled
// takes an http response byte stream and yields payload bytes and chunk events
// ----------------------------------------------------------------------------
// usage
//   in_*  : response stream, one byte per transaction in in_tdata
//   out_* : results; out_tuser is the kind (payload, chunk size, end of body,
//           not chunked), out_tlast marks the final byte of a chunk (its
//           trailing cr lf included)
//   header and size-line bytes give no result; the lf closing a size line
//   gives a chunk-size or end-of-body result, the lf closing the headers of a
//   response without chunked encoding gives a not-chunked result
// timing
//   one byte per clock sustained while out_tready stays high; a taken byte is
//   held in the input register and its result is loaded into the output
//   register once that register has room, and is offered from there
//   the per-byte parse state update is the only loop
// reset and stall
//   rst_n (synchronous) returns to the header phase with both registers empty
//   while the receiver holds out_tready low the result is kept; one more byte
//   is taken into the input register, then in_tready drops
//   after end of body or not-chunked every further byte is swallowed
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] out_byte, [39:8] chunk_length, [71:40] total_length
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast   // last_of_chunk
);

  // chunk size register width, capped at the 32-bit result field
  localparam int SZ_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         out_valid_r;
  hcbd_result_t out_r;
  hcbd_result_t res;
  logic         advance;

  // the byte in the input register moves on once the output register has room
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  hcbd_parser #(
    .SZ_W (SZ_W)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (in_byte_r),
    .res     (res)
  );

  // result register; bytes with no result leave it untouched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.total_length, out_r.chunk_length, out_r.data_byte};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule

>>> rtl/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker - port-level checks of the chunked body decoder
// watches the result channel for stalls, field consistency and the end rule
// ----------------------------------------------------------------------------
module hcbd_checker
  import hcbd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // only payload bytes close a chunk
  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_PAYLOAD)
    else $error("tlast on a non-payload result");

  // an announced chunk is never empty and carries no byte or total
  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SIZE |->
      out_tdata[39:8] != 32'd0 && out_tdata[7:0] == 8'd0 && out_tdata[71:40] == 32'd0)
    else $error("bad chunk size result");

  // nothing follows end of body or not-chunked
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tuser == KIND_END || out_tuser == KIND_NOT_CHUNKED)
      |=> !out_tvalid)
    else $error("result after end of stream");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);
